### sv/oets_pkg.sv
// Shared types and constants of the odd-even transposition sorter.
package oets_pkg;

    // Width of one stored element
    localparam int ELEM_W = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;    // write the incoming item into the store
        logic rd_en;      // read the store at the read address
        logic sort_rd;    // the read belongs to a sort pass
        logic start_bit;  // low bit of the left position of each pair in this pass
        logic out_load;   // capture read data into the output register
        logic out_final;  // flag for the captured result: last of the batch
        logic out_ovf;    // flag for the captured result: batch overflowed
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic busy;       // sort pass still has reads in flight or a write pending
    } t_dp_status;

endpackage

### sv/oets_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oets_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/oets_dpath.sv
// Datapath of the sorter: element store, compare-exchange unit and output register.
module oets_dpath #(
    parameter int MAX_ELEMS = 64,
    localparam int AW = $clog2(MAX_ELEMS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oets_pkg::t_dp_cmd                 i_cmd,
    output oets_pkg::t_dp_status              o_status,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [AW-1:0]                     i_rd_addr,
    input  logic signed [oets_pkg::ELEM_W-1:0] i_element,
    output logic signed [oets_pkg::ELEM_W-1:0] o_sorted_element,
    output logic                              o_final_result,
    output logic                              o_overflow
);

    logic [oets_pkg::ELEM_W-1:0] w_rd_data;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [oets_pkg::ELEM_W-1:0] w_wdata;
    logic                        w_is_left;
    logic                        w_is_right;
    logic                        w_swap;

    logic                        r_arr_v;
    logic [AW-1:0]               r_arr_idx;
    logic [oets_pkg::ELEM_W-1:0] r_hold;
    logic                        r_pend_v;
    logic [AW-1:0]               r_pend_addr;
    logic [oets_pkg::ELEM_W-1:0] r_pend_val;
    logic [oets_pkg::ELEM_W-1:0] r_out_data;
    logic                        r_out_final;
    logic                        r_out_ovf;

    oets_ram #(
        .WIDTH (oets_pkg::ELEM_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Classify the element arriving from a sort read
    assign w_is_left  = r_arr_v && (r_arr_idx[0] == i_cmd.start_bit);
    assign w_is_right = r_arr_v && (r_arr_idx[0] != i_cmd.start_bit) && (r_arr_idx != '0);
    assign w_swap     = $signed(r_hold) > $signed(w_rd_data);

    // Pick the single write of this cycle: load, pending upper value, or lower value
    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_wr_addr;
        w_wdata = i_element;
        if (i_cmd.load_we) begin
            w_we = 1'b1;
        end else if (r_pend_v) begin
            w_we    = 1'b1;
            w_waddr = r_pend_addr;
            w_wdata = r_pend_val;
        end else if (w_is_right) begin
            w_we    = 1'b1;
            w_waddr = r_arr_idx - AW'(1);
            w_wdata = w_swap ? w_rd_data : r_hold;
        end
    end

    // Track reads in flight and the deferred write of each pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arr_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_arr_v  <= i_cmd.sort_rd;
            r_pend_v <= w_is_right;
        end
    end

    // Hold pair operands and the upper value of the pair
    always_ff @(posedge i_clk) begin
        r_arr_idx <= i_rd_addr;
        if (w_is_left) begin
            r_hold <= w_rd_data;
        end
        if (w_is_right) begin
            r_pend_addr <= r_arr_idx;
            r_pend_val  <= w_swap ? r_hold : w_rd_data;
        end
    end

    // Capture the next result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data  <= w_rd_data;
            r_out_final <= i_cmd.out_final;
            r_out_ovf   <= i_cmd.out_ovf;
        end
    end

    assign o_status.busy    = r_arr_v | r_pend_v;
    assign o_sorted_element = r_out_data;
    assign o_final_result   = r_out_final;
    assign o_overflow       = r_out_ovf;

endmodule

### sv/oets_ctrl.sv
// Controller of the sorter: load, sort passes and emission sequencing.
module oets_ctrl #(
    parameter int MAX_ELEMS = 64,
    localparam int AW = $clog2(MAX_ELEMS),
    localparam int CW = $clog2(MAX_ELEMS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_final_element,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output oets_pkg::t_dp_cmd    o_cmd,
    input  oets_pkg::t_dp_status i_status,
    output logic [AW-1:0]        o_wr_addr,
    output logic [AW-1:0]        o_rd_addr
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT,
        S_SETTLE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_phase;
    logic [CW-1:0] r_idx;
    logic          r_overflow;
    logic          r_out_valid;

    logic          w_in_acc;
    logic          w_has_room;
    logic          w_idx_last;
    logic [CW-1:0] w_phase_nxt;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_has_room  = r_count < CW'(MAX_ELEMS);
    assign w_idx_last  = r_idx == (r_count - CW'(1));
    assign w_phase_nxt = r_phase + CW'(1);
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_rd_addr   = r_idx[AW-1:0];

    // Decode commands from the current state
    always_comb begin
        o_cmd           = '0;
        o_cmd.start_bit = ~r_phase[0];
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_we = w_in_acc && w_has_room;
            end
            S_SORT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.sort_rd = 1'b1;
            end
            S_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_EMIT_LD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_final = w_idx_last;
                o_cmd.out_ovf   = r_overflow;
            end
            default: begin
            end
        endcase
    end

    // Advance state, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_idx       <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_has_room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_final_element) begin
                            r_state <= S_SORT;
                        end
                    end
                end
                S_SORT: begin
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_SETTLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_SETTLE: begin
                    if (!i_status.busy) begin
                        if (w_phase_nxt == r_count) begin
                            r_phase <= '0;
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_phase <= w_phase_nxt;
                            r_state <= S_SORT;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (w_idx_last) begin
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                            r_idx      <= '0;
                            r_state    <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

### sv/odd_even_transposition_sorter_top.sv
// Top level of the odd-even transposition sorter.
//
// Input channel (i_in_valid / o_in_stall): one signed element per item, with
// i_final_element marking the last of a batch. Up to MAX_ELEMS elements are
// stored, one per cycle; further elements of the batch are dropped and every
// result of that batch then carries o_overflow.
// After the final item the block runs n compare-exchange passes over the n
// stored elements. Each pass streams the store through one comparator: it
// reads every stored element in turn, then drains until the last read has
// arrived and, when the last position closes a pair, its upper value is
// written; the input stalls meanwhile.
// Output channel (o_out_valid / i_out_stall): n result items in ascending
// signed order, the last one with o_final_result. Each result passes a store
// read, a capture and a handshake that waits while the receiver stalls; a
// stalled result holds its value. After the last result is taken the block
// accepts a new batch.
// Reset (synchronous, active low) empties the batch and clears the flags;
// the store contents are not cleared and need no clearing pass.
module odd_even_transposition_sorter_top #(
    parameter int MAX_ELEMS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [oets_pkg::ELEM_W-1:0] i_element,
    input  logic                              i_final_element,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [oets_pkg::ELEM_W-1:0] o_sorted_element,
    output logic                              o_final_result,
    output logic                              o_overflow
);

    localparam int AW = $clog2(MAX_ELEMS);

    oets_pkg::t_dp_cmd    w_cmd;
    oets_pkg::t_dp_status w_status;
    logic [AW-1:0]        w_wr_addr;
    logic [AW-1:0]        w_rd_addr;

    oets_ctrl #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_final_element (i_final_element),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd           (w_cmd),
        .i_status        (w_status),
        .o_wr_addr       (w_wr_addr),
        .o_rd_addr       (w_rd_addr)
    );

    oets_dpath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_wr_addr        (w_wr_addr),
        .i_rd_addr        (w_rd_addr),
        .i_element        (i_element),
        .o_sorted_element (o_sorted_element),
        .o_final_result   (o_final_result),
        .o_overflow       (o_overflow)
    );

endmodule

### sv/oets_checker.sv
// Port-level checks of the sorter and their binding to the top level.
module oets_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_final_element,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [oets_pkg::ELEM_W-1:0] o_sorted_element,
    input logic                              o_final_result,
    input logic                              o_overflow
);

    // No new item is taken while results are being delivered
    a_no_input_while_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall
    ) else $error("input open while a result is pending");

    // The final item of a batch closes the input for sorting
    a_final_closes_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_final_element) |=> o_in_stall
    ) else $error("input still open after final item");

    // Nothing follows the last result of a batch
    a_last_ends_batch: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_final_result) |=> !o_out_valid
    ) else $error("result after the last of the batch");

    // A stalled result holds
    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sorted_element) &&
             $stable(o_final_result) && $stable(o_overflow))
    ) else $error("stalled result changed");

endmodule

bind odd_even_transposition_sorter_top oets_checker u_oets_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_final_element  (i_final_element),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_sorted_element (o_sorted_element),
    .o_final_result   (o_final_result),
    .o_overflow       (o_overflow)
);

### dv/odd_even_transposition_sorter_top_test.sv
`timescale 1ns / 1ps
// Testbench of the odd-even transposition sorter: directed and random batches.
module odd_even_transposition_sorter_top_test;

    localparam int MAX_ELEMS = 64;
    localparam int ITEM_GOAL = 430;
    localparam int IDLE_PCT  = 7;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_LEN = 64;
    localparam int DIR_ROWS  = 19;

    typedef logic signed [oets_pkg::ELEM_W-1:0] t_elem;

    localparam t_elem ELEM_MIN = {1'b1, {(oets_pkg::ELEM_W-1){1'b0}}};
    localparam t_elem ELEM_MAX = {1'b0, {(oets_pkg::ELEM_W-1){1'b1}}};

    // One result item as the block should emit it
    typedef struct {
        t_elem value;
        logic  last;
        logic  ovf;
    } t_sorted;

    // One row of the directed table; typed rows are single-element batches
    typedef struct {
        t_elem elem;
        logic  fin;
        bit    typed;
        t_elem want;
    } t_row;

    logic  i_clk;
    logic  i_rst_n         = 1'b0;
    logic  i_in_valid      = 1'b0;
    logic  o_in_stall;
    t_elem i_element       = '0;
    logic  i_final_element = 1'b0;
    logic  o_out_valid;
    logic  i_out_stall     = 1'b0;
    t_elem o_sorted_element;
    logic  o_final_result;
    logic  o_overflow;

    // Behavioral copy of the batch being collected
    t_elem   sort_store [MAX_ELEMS];
    int      sort_count   = 0;
    bit      sort_dropped = 1'b0;
    t_sorted batch_out [$];
    t_sorted sorted_due [$];

    int  items_sent   = 0;
    int  batches_sent = 0;
    int  ovf_batches  = 0;
    int  results_seen = 0;
    int  errors       = 0;
    bit  calm_in      = 1'b0;
    bit  calm_out     = 1'b0;

    t_row dir_rows [DIR_ROWS] = '{
        '{ELEM_MAX, 1'b1, 1'b1, ELEM_MAX},
        '{ELEM_MIN, 1'b1, 1'b1, ELEM_MIN},
        '{0,        1'b1, 1'b1, 0},
        '{-1,       1'b1, 1'b1, -1},
        '{5,        1'b0, 1'b0, 0},
        '{ELEM_MIN, 1'b0, 1'b0, 0},
        '{ELEM_MAX, 1'b0, 1'b0, 0},
        '{-1,       1'b0, 1'b0, 0},
        '{0,        1'b0, 1'b0, 0},
        '{1,        1'b1, 1'b0, 0},
        '{3,        1'b0, 1'b0, 0},
        '{3,        1'b0, 1'b0, 0},
        '{-3,       1'b1, 1'b0, 0},
        '{7,        1'b0, 1'b0, 0},
        '{-7,       1'b1, 1'b0, 0},
        '{4,        1'b0, 1'b0, 0},
        '{3,        1'b0, 1'b0, 0},
        '{2,        1'b0, 1'b0, 0},
        '{1,        1'b1, 1'b0, 0}
    };

    odd_even_transposition_sorter_top #(.MAX_ELEMS(MAX_ELEMS)) dut (.*);

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Store one element; on the last one sort the batch into batch_out
    function automatic void collect_element(t_elem value, logic fin);
        int    n;
        t_elem tmp;
        batch_out.delete();
        if (sort_count < MAX_ELEMS) begin
            sort_store[sort_count] = value;
            sort_count++;
        end else begin
            sort_dropped = 1'b1;
        end
        if (fin) begin
            n = sort_count;
            // even passes pair (1,2),(3,4)..., odd passes pair (0,1),(2,3)...
            for (int p = 0; p < n; p++) begin
                for (int i = (p % 2 == 1) ? 0 : 1; i + 1 < n; i += 2) begin
                    if (sort_store[i] > sort_store[i+1]) begin
                        tmp             = sort_store[i];
                        sort_store[i]   = sort_store[i+1];
                        sort_store[i+1] = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                batch_out.push_back('{sort_store[k], logic'(k + 1 == n), sort_dropped});
            end
            sort_count   = 0;
            sort_dropped = 1'b0;
        end
    endfunction

    // Mix full-range values, extremes and a narrow band that yields duplicates
    function automatic t_elem pick_value();
        case ($urandom_range(0, 9))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2, 3:    return t_elem'($urandom_range(0, 16)) - 8;
            default: return t_elem'($urandom);
        endcase
    endfunction

    // Offer one item, wait for it to be taken, then queue what it should produce
    task automatic offer_item(t_elem value, logic fin, bit typed, t_elem want);
        while (!calm_in && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element       <= value;
        i_final_element <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        collect_element(value, fin);
        if (typed) begin
            sorted_due.push_back('{want, 1'b1, 1'b0});
        end else begin
            foreach (batch_out[k]) sorted_due.push_back(batch_out[k]);
        end
        items_sent++;
        if (fin) begin
            batches_sent++;
            if (batch_out.size() > 0 && batch_out[0].ovf) ovf_batches++;
        end
    endtask

    task automatic send_batch(int n);
        for (int k = 0; k < n; k++) begin
            offer_item(pick_value(), logic'(k == n - 1), 1'b0, '0);
        end
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (sorted_due.size() != 0) @(posedge i_clk);
    endtask

    // Sender: reset, directed table, random batches, then drain
    initial begin : stimulus
        int batch_idx;
        int size;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_item(dir_rows[r].elem, dir_rows[r].fin, dir_rows[r].typed, dir_rows[r].want);
        end

        batch_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            case (batch_idx)
                2:       size = MAX_ELEMS;
                8:       size = MAX_ELEMS + 2 + $urandom_range(0, 4);
                16:      size = MAX_ELEMS + 1;
                default: size = $urandom_range(1, 12);
            endcase
            calm_in = (items_sent >= 200 && items_sent < 300);
            send_batch(size);
            if (batch_idx == 5) wait_results();
            batch_idx++;
        end

        wait_results();
        repeat (DRAIN_LEN) @(posedge i_clk);
        $display("Ran %0d items in %0d batches (%0d overflowing, up to %0d elements).",
                 items_sent, batches_sent, ovf_batches, MAX_ELEMS + 6);
        $display("Checked %0d sorted results with random idles and a long output hold.",
                 results_seen);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: check each taken result, then pick the stall for the next cycle
    initial begin : result_side
        t_sorted want;
        int      hold_left;
        bit      hold_done;
        logic    stall_next;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (sorted_due.size() == 0) begin
                    $error("unexpected result: sorted_element %0d", o_sorted_element);
                    errors++;
                end else begin
                    want = sorted_due.pop_front();
                    if (o_sorted_element !== want.value) begin
                        $error("sorted_element: expected %0d, got %0d",
                               want.value, o_sorted_element);
                        errors++;
                    end
                    if (o_final_result !== want.last) begin
                        $error("final_result: expected %0b, got %0b", want.last, o_final_result);
                        errors++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %0b, got %0b", want.ovf, o_overflow);
                        errors++;
                    end
                end
                results_seen++;
            end
            calm_out = (results_seen >= 300 && results_seen < 450);
            // hold the output once while more than four results are owed so the input side backs up
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && results_seen >= 150 && sorted_due.size() > 4) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_LEN - 1;
                stall_next = 1'b1;
            end else begin
                stall_next = !calm_out && ($urandom_range(0, 99) < IDLE_PCT);
            end
            i_out_stall <= stall_next;
        end
    end

    // Watchdog
    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results outstanding", sorted_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
sv/oets_pkg.sv
sv/oets_ram.sv
sv/oets_dpath.sv
sv/oets_ctrl.sv
sv/odd_even_transposition_sorter_top.sv
sv/oets_checker.sv
dv/odd_even_transposition_sorter_top_test.sv
